/* hw/rtl/sorted_list_insert_table_macros.svh */
// Assertion macros for the sorted list insert table.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SORTED_LIST_INSERT_TABLE_MACROS_SVH
`define SORTED_LIST_INSERT_TABLE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SLIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SLIT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define SLIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/slit_pkg.sv */
// Shared types and constants for the sorted list insert table.
// No dependencies; used by slit_cell and sorted_list_insert_table.
package slit_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_ORDERED = 2'd0,
        OP_BEFORE  = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;      // insert the new value this cycle
        logic eq_mode;  // match on equality with the search value
        logic rot;      // rotate the held entries one place toward the head
    } t_cell_ctrl;

endpackage

/* hw/rtl/slit_cell.sv */
// One cell of the list chain: holds one entry and its occupancy flag.
// Depends on slit_pkg.
module slit_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slit_pkg::t_cell_ctrl i_ctrl,
    input  slit_pkg::t_word     i_value,
    input  slit_pkg::t_word     i_search_value,
    input  slit_pkg::t_word     i_left_value,
    input  logic                i_left_valid,
    input  slit_pkg::t_word     i_right_value,
    input  logic                i_right_valid,
    input  slit_pkg::t_word     i_head_value,
    input  logic                i_taken,
    output logic                o_taken,
    output slit_pkg::t_word     o_value,
    output logic                o_valid
);
    import slit_pkg::*;

    t_word r_value;
    logic  r_valid;
    t_word n_value;
    logic  n_valid;
    logic  w_hit;
    logic  w_place;

    // First matching cell, or first empty cell, takes the new value.
    assign w_hit   = r_valid && (i_ctrl.eq_mode ? (r_value == i_search_value)
                                                : (r_value >= i_value));
    assign w_place = !i_taken && (w_hit || !r_valid);
    assign o_taken = i_taken || w_place;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (i_taken) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else if (w_place) begin
                n_value = i_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.rot && r_valid) begin
            // the tail of the occupied run wraps back to the head entry
            n_value = i_right_valid ? i_right_value : i_head_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

/* hw/rtl/sorted_list_insert_table.sv */
// Sorted list insert table: an ordered list of up to DEPTH signed words held in a cell chain.
// Insert: its result is in the output register the next cycle after it is accepted.
// Read out: ST_EMPTY if empty, else entries leave one per cycle as the chain rotates.
// The rotation through the cells sets the read-out rate; backpressure holds the rotation.
// Reset (synchronous, active low) empties the list and clears the output valid flag.
`include "sorted_list_insert_table_macros.svh"

module sorted_list_insert_table #(
    parameter int DEPTH = slit_pkg::DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  slit_pkg::t_word              i_value,
    input  slit_pkg::t_word              i_search_value,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output slit_pkg::t_word              o_entry_value,
    output logic [slit_pkg::INDEX_W-1:0] o_entry_index,
    output logic [slit_pkg::COUNT_W-1:0] o_entry_count,
    output logic [1:0]                   o_status,
    output logic                         o_last
);
    import slit_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_rd_idx;
    logic [CW-1:0]     n_rd_idx;

    // output register
    logic              r_out_valid;
    logic              n_out_valid;
    t_word             r_out_value;
    t_word             n_out_value;
    logic [INDEX_W-1:0] r_out_index;
    logic [INDEX_W-1:0] n_out_index;
    logic [COUNT_W-1:0] r_out_count;
    logic [COUNT_W-1:0] n_out_count;
    t_status           r_out_status;
    t_status           n_out_status;
    logic              r_out_last;
    logic              n_out_last;

    t_op               w_op;
    logic              w_slot_free;
    logic              w_acc;
    logic              w_emit;
    logic              w_full;
    logic              w_rd_last;
    t_cell_ctrl        w_ctrl;

    t_word             w_cell_value [DEPTH];
    logic [DEPTH-1:0]  w_cell_valid;
    logic [DEPTH:0]    w_taken;

    assign w_op        = t_op'(i_operation);
    assign w_full      = (r_count == CW'(DEPTH));
    // The output register frees up when empty or when its transaction is taken.
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_slot_free);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_emit      = (r_state == S_READ) && w_slot_free;
    assign w_rd_last   = (CW'(r_rd_idx + CW'(1)) == r_count);

    // Broadcast control to the chain.
    always_comb begin
        w_ctrl.ins     = w_acc && ((w_op == OP_ORDERED) || (w_op == OP_BEFORE)) && !w_full;
        w_ctrl.eq_mode = (w_op == OP_BEFORE);
        w_ctrl.rot     = w_emit;
    end

    // Cell chain: each cell sees its neighbors and the head entry.
    assign w_taken[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_word w_left_value;
        logic  w_left_valid;
        t_word w_right_value;
        logic  w_right_valid;

        if (k == 0) begin : g_head
            assign w_left_value = '0;
            assign w_left_valid = 1'b0;
        end else begin : g_body
            assign w_left_value = w_cell_value[k-1];
            assign w_left_valid = w_cell_valid[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_cell_value[k+1];
            assign w_right_valid = w_cell_valid[k+1];
        end

        slit_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_value        (i_value),
            .i_search_value (i_search_value),
            .i_left_value   (w_left_value),
            .i_left_valid   (w_left_valid),
            .i_right_value  (w_right_value),
            .i_right_valid  (w_right_valid),
            .i_head_value   (w_cell_value[0]),
            .i_taken        (w_taken[k]),
            .o_taken        (w_taken[k+1]),
            .o_value        (w_cell_value[k]),
            .o_valid        (w_cell_valid[k])
        );
    end

    // Sequencer and output register.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_index  = r_out_index;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_index  = '0;
                    n_out_count  = COUNT_W'(r_count);
                    n_out_status = ST_OK;
                    n_out_last   = 1'b1;
                    case (w_op)
                        OP_ORDERED, OP_BEFORE: begin
                            if (w_full) begin
                                // drop the insert and flag it
                                n_out_status = ST_FULL;
                            end else begin
                                n_count     = CW'(r_count + CW'(1));
                                n_out_count = COUNT_W'(CW'(r_count + CW'(1)));
                            end
                        end
                        OP_READ: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                // entries follow from the read state
                                n_out_valid = 1'b0;
                                n_rd_idx    = '0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            // no operation: acknowledge only
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = w_cell_value[0];
                    n_out_index  = INDEX_W'(r_rd_idx);
                    n_out_count  = COUNT_W'(r_count);
                    n_out_status = ST_OK;
                    n_out_last   = w_rd_last;
                    n_rd_idx     = CW'(r_rd_idx + CW'(1));
                    if (w_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_index  <= n_out_index;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_entry_index = r_out_index;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

    // Occupancy flags in the cells must agree with the count.
    `SLIT_ASSERT(a_valid_matches_count, ($countones(w_cell_valid) == int'(r_count)), "cell occupancy differs from count")
    `SLIT_ASSERT(a_count_bound, (r_count <= CW'(DEPTH)), "count beyond depth")
    `SLIT_ASSERT(a_state_onehot, $onehot(r_state), "state not one-hot")
    `SLIT_ASSERT_NEXT(a_read_ends, (w_emit && w_rd_last), (r_state == S_IDLE && o_last), "read out did not end on last entry")
    `SLIT_ASSERT_NEXT(a_full_flag, (w_acc && w_full && (w_op == OP_ORDERED || w_op == OP_BEFORE)), (o_status == ST_FULL && $stable(r_count)), "full insert not flagged or count moved")

endmodule
